### hdl/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// shared widths, constants and transaction types of the quaternion rotator
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int QUAT_FRAC_BITS = 14;

    localparam int IN_W   = 16;
    localparam int OUT_W  = 17;
    localparam int M1_W   = 2 * IN_W;
    localparam int SQ_W   = 2 * IN_W - 1;
    localparam int P_W    = 2 * IN_W + 1;
    localparam int N_W    = 2 * IN_W + 1;
    localparam int M3_W   = P_W + IN_W;
    localparam int R_W    = M3_W + 2;
    localparam int MAG_W  = R_W;
    localparam int DEN_W  = N_W;
    localparam int DIV_W  = DEN_W + 1;
    localparam int D_W    = MAG_W + 2;
    localparam int QW     = OUT_W + 1;
    localparam int CMP_W  = N_W + 7;

    localparam logic [DEN_W-1:0] UNITY = DEN_W'(64'd1 << (2 * QUAT_FRAC_BITS));
    localparam logic [CMP_W-1:0] NEAR_LO = CMP_W'(64'd99 * (64'd1 << (2 * QUAT_FRAC_BITS)));
    localparam logic [CMP_W-1:0] NEAR_HI = CMP_W'(64'd101 * (64'd1 << (2 * QUAT_FRAC_BITS)));

    localparam logic signed [OUT_W+1:0] OUT_MAX = (OUT_W+2)'(65535);
    localparam logic signed [OUT_W+1:0] OUT_MIN = -(OUT_W+2)'(65536);

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic [DEN_W-1:0]      den;
        logic                  zero;
    } rot_res_t;

    typedef struct packed {
        logic [2:0][QW-1:0] quo;
        logic [2:0]         neg;
        logic               zero;
    } div_res_t;

endpackage

### hdl/quaternion_vector_rotate.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// rotates a body frame vector into the world frame with a Q2.14 quaternion
// ----------------------------------------------------------------------------
// One transaction per clock while out_stall is low, fully pipelined. An input
// transaction passes through the products and sums, the 18 stage divider with
// one quotient bit per stage, and the output register. A stall only
// holds the stages that are full, so bubbles close up behind a stalled
// result. If the squared norm is within 1% of unity it is taken as exactly one,
// otherwise the result is divided by it; results round half away from zero.
// A zero quaternion gives zero_quat_error with all outputs zero.
module quaternion_vector_rotate
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [15:0]       quat_w,
    input  logic signed [15:0]       quat_x,
    input  logic signed [15:0]       quat_y,
    input  logic signed [15:0]       quat_z,
    input  logic signed [15:0]       accel_x,
    input  logic signed [15:0]       accel_y,
    input  logic signed [15:0]       accel_z,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [16:0]       rot_x,
    output logic signed [16:0]       rot_y,
    output logic signed [16:0]       rot_z,
    output logic                     zero_quat_error
);

    localparam int SV_W = qvr_pkg::OUT_W + 2;

    logic                    rot_valid;
    logic                    rot_ready;
    qvr_pkg::rot_res_t       rot_data;
    logic                    div_valid;
    logic                    out_ready;
    qvr_pkg::div_res_t       div_data;
    logic                    in_ready;

    logic                    valid_reg;
    logic [qvr_pkg::OUT_W-1:0] res_reg [3];
    logic [qvr_pkg::OUT_W-1:0] res_next [3];
    logic                    err_reg;
    logic signed [SV_W-1:0]  sval [3];

    qvr_rotate u_rotate
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .quat_w    (quat_w),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_data  (rot_data)
    );

    qvr_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .in_data   (rot_data),
        .out_valid (div_valid),
        .out_ready (out_ready),
        .out_data  (div_data)
    );

    assign in_stall  = !in_ready;
    assign out_ready = !valid_reg || !out_stall;

    // sign, saturation and zero quaternion override
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sval[i] = div_data.neg[i] ? -SV_W'(div_data.quo[i]) : SV_W'(div_data.quo[i]);
            if (div_data.zero)
            begin
                res_next[i] = '0;
            end
            else if (sval[i] > qvr_pkg::OUT_MAX)
            begin
                res_next[i] = qvr_pkg::OUT_W'(qvr_pkg::OUT_MAX);
            end
            else if (sval[i] < qvr_pkg::OUT_MIN)
            begin
                res_next[i] = qvr_pkg::OUT_W'(qvr_pkg::OUT_MIN);
            end
            else
            begin
                res_next[i] = qvr_pkg::OUT_W'(sval[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            res_reg <= res_next;
            err_reg <= div_data.zero;
        end
    end

    assign out_valid       = valid_reg;
    assign rot_x           = res_reg[0];
    assign rot_y           = res_reg[1];
    assign rot_z           = res_reg[2];
    assign zero_quat_error = err_reg;

    a_zero_outputs: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && err_reg) |-> (rot_x == '0 && rot_y == '0 && rot_z == '0))
        else $error("zero quaternion result not cleared");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> !in_stall)
        else $error("input stalled with empty output register");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg) |-> $past(div_valid))
        else $error("result appeared without divider output");

endmodule

### hdl/qvr_rotate.sv
// ----------------------------------------------------------------------------
// qvr_rotate
// four stage product pipeline: q*(0,v), norm and unity check, then *conj(q)
// ----------------------------------------------------------------------------
module qvr_rotate
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [15:0]         quat_w,
    input  logic signed [15:0]         quat_x,
    input  logic signed [15:0]         quat_y,
    input  logic signed [15:0]         quat_z,
    input  logic signed [15:0]         accel_x,
    input  logic signed [15:0]         accel_y,
    input  logic signed [15:0]         accel_z,
    output logic                       out_valid,
    input  logic                       out_ready,
    output qvr_pkg::rot_res_t          out_data
);

    logic [3:0] v_reg;
    logic [4:0] rdy;

    logic signed [qvr_pkg::M1_W-1:0] m1_reg [12];
    logic signed [qvr_pkg::M1_W-1:0] m1_next [12];
    logic [qvr_pkg::SQ_W-1:0]        sq_reg [4];
    logic [qvr_pkg::SQ_W-1:0]        sq_next [4];
    logic signed [15:0]              q1_reg [4];

    logic signed [qvr_pkg::P_W-1:0]  p_reg [4];
    logic signed [qvr_pkg::P_W-1:0]  p_next [4];
    logic signed [15:0]              q2_reg [4];
    logic [qvr_pkg::DEN_W-1:0]       den2_reg;
    logic [qvr_pkg::DEN_W-1:0]       den2_next;
    logic                            zero2_reg;
    logic                            zero2_next;
    logic [qvr_pkg::N_W-1:0]         norm;
    logic [qvr_pkg::CMP_W-1:0]       norm100;

    logic signed [qvr_pkg::M3_W-1:0] m3_reg [12];
    logic signed [qvr_pkg::M3_W-1:0] m3_next [12];
    logic [qvr_pkg::DEN_W-1:0]       den3_reg;
    logic                            zero3_reg;

    logic signed [qvr_pkg::R_W-1:0]  r_sum [3];
    qvr_pkg::rot_res_t               res_reg;
    qvr_pkg::rot_res_t               res_next;

    assign rdy[4] = out_ready;
    assign rdy[3] = !v_reg[3] || rdy[4];
    assign rdy[2] = !v_reg[2] || rdy[3];
    assign rdy[1] = !v_reg[1] || rdy[2];
    assign rdy[0] = !v_reg[0] || rdy[1];
    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0]) v_reg[0] <= in_valid;
            if (rdy[1]) v_reg[1] <= v_reg[0];
            if (rdy[2]) v_reg[2] <= v_reg[1];
            if (rdy[3]) v_reg[3] <= v_reg[2];
        end
    end

    // stage 1: products of q and v, squares of q
    always_comb
    begin
        m1_next[0]  = qvr_pkg::M1_W'(quat_x) * qvr_pkg::M1_W'(accel_x);
        m1_next[1]  = qvr_pkg::M1_W'(quat_y) * qvr_pkg::M1_W'(accel_y);
        m1_next[2]  = qvr_pkg::M1_W'(quat_z) * qvr_pkg::M1_W'(accel_z);
        m1_next[3]  = qvr_pkg::M1_W'(quat_w) * qvr_pkg::M1_W'(accel_x);
        m1_next[4]  = qvr_pkg::M1_W'(quat_y) * qvr_pkg::M1_W'(accel_z);
        m1_next[5]  = qvr_pkg::M1_W'(quat_z) * qvr_pkg::M1_W'(accel_y);
        m1_next[6]  = qvr_pkg::M1_W'(quat_w) * qvr_pkg::M1_W'(accel_y);
        m1_next[7]  = qvr_pkg::M1_W'(quat_x) * qvr_pkg::M1_W'(accel_z);
        m1_next[8]  = qvr_pkg::M1_W'(quat_z) * qvr_pkg::M1_W'(accel_x);
        m1_next[9]  = qvr_pkg::M1_W'(quat_w) * qvr_pkg::M1_W'(accel_z);
        m1_next[10] = qvr_pkg::M1_W'(quat_x) * qvr_pkg::M1_W'(accel_y);
        m1_next[11] = qvr_pkg::M1_W'(quat_y) * qvr_pkg::M1_W'(accel_x);
        sq_next[0]  = qvr_pkg::SQ_W'(qvr_pkg::M1_W'(quat_w) * qvr_pkg::M1_W'(quat_w));
        sq_next[1]  = qvr_pkg::SQ_W'(qvr_pkg::M1_W'(quat_x) * qvr_pkg::M1_W'(quat_x));
        sq_next[2]  = qvr_pkg::SQ_W'(qvr_pkg::M1_W'(quat_y) * qvr_pkg::M1_W'(quat_y));
        sq_next[3]  = qvr_pkg::SQ_W'(qvr_pkg::M1_W'(quat_z) * qvr_pkg::M1_W'(quat_z));
    end

    // stage 2: p = q*(0,v), norm, unity window
    always_comb
    begin
        p_next[0] = -(qvr_pkg::P_W'(m1_reg[0]) + qvr_pkg::P_W'(m1_reg[1])
                      + qvr_pkg::P_W'(m1_reg[2]));
        p_next[1] = qvr_pkg::P_W'(m1_reg[3]) + qvr_pkg::P_W'(m1_reg[4])
                    - qvr_pkg::P_W'(m1_reg[5]);
        p_next[2] = qvr_pkg::P_W'(m1_reg[6]) - qvr_pkg::P_W'(m1_reg[7])
                    + qvr_pkg::P_W'(m1_reg[8]);
        p_next[3] = qvr_pkg::P_W'(m1_reg[9]) + qvr_pkg::P_W'(m1_reg[10])
                    - qvr_pkg::P_W'(m1_reg[11]);
        norm = qvr_pkg::N_W'(sq_reg[0]) + qvr_pkg::N_W'(sq_reg[1])
               + qvr_pkg::N_W'(sq_reg[2]) + qvr_pkg::N_W'(sq_reg[3]);
        norm100 = qvr_pkg::CMP_W'(norm) * qvr_pkg::CMP_W'(100);
        zero2_next = (norm == '0);
        if (norm100 > qvr_pkg::NEAR_LO && norm100 < qvr_pkg::NEAR_HI)
        begin
            den2_next = qvr_pkg::UNITY;
        end
        else
        begin
            den2_next = norm;
        end
    end

    // stage 3: products of p and conj(q)
    always_comb
    begin
        m3_next[0]  = qvr_pkg::M3_W'(p_reg[0]) * qvr_pkg::M3_W'(q2_reg[1]);
        m3_next[1]  = qvr_pkg::M3_W'(p_reg[1]) * qvr_pkg::M3_W'(q2_reg[0]);
        m3_next[2]  = qvr_pkg::M3_W'(p_reg[2]) * qvr_pkg::M3_W'(q2_reg[3]);
        m3_next[3]  = qvr_pkg::M3_W'(p_reg[3]) * qvr_pkg::M3_W'(q2_reg[2]);
        m3_next[4]  = qvr_pkg::M3_W'(p_reg[0]) * qvr_pkg::M3_W'(q2_reg[2]);
        m3_next[5]  = qvr_pkg::M3_W'(p_reg[1]) * qvr_pkg::M3_W'(q2_reg[3]);
        m3_next[6]  = qvr_pkg::M3_W'(p_reg[2]) * qvr_pkg::M3_W'(q2_reg[0]);
        m3_next[7]  = qvr_pkg::M3_W'(p_reg[3]) * qvr_pkg::M3_W'(q2_reg[1]);
        m3_next[8]  = qvr_pkg::M3_W'(p_reg[0]) * qvr_pkg::M3_W'(q2_reg[3]);
        m3_next[9]  = qvr_pkg::M3_W'(p_reg[1]) * qvr_pkg::M3_W'(q2_reg[2]);
        m3_next[10] = qvr_pkg::M3_W'(p_reg[2]) * qvr_pkg::M3_W'(q2_reg[1]);
        m3_next[11] = qvr_pkg::M3_W'(p_reg[3]) * qvr_pkg::M3_W'(q2_reg[0]);
    end

    // stage 4: sums, sign and magnitude
    always_comb
    begin
        r_sum[0] = -qvr_pkg::R_W'(m3_reg[0]) + qvr_pkg::R_W'(m3_reg[1])
                   - qvr_pkg::R_W'(m3_reg[2]) + qvr_pkg::R_W'(m3_reg[3]);
        r_sum[1] = -qvr_pkg::R_W'(m3_reg[4]) + qvr_pkg::R_W'(m3_reg[5])
                   + qvr_pkg::R_W'(m3_reg[6]) - qvr_pkg::R_W'(m3_reg[7]);
        r_sum[2] = -qvr_pkg::R_W'(m3_reg[8]) - qvr_pkg::R_W'(m3_reg[9])
                   + qvr_pkg::R_W'(m3_reg[10]) + qvr_pkg::R_W'(m3_reg[11]);
        res_next.den  = den3_reg;
        res_next.zero = zero3_reg;
        for (int i = 0; i < 3; i++)
        begin
            res_next.neg[i] = r_sum[i][qvr_pkg::R_W-1];
            res_next.mag[i] = r_sum[i][qvr_pkg::R_W-1] ? qvr_pkg::MAG_W'(-r_sum[i])
                                                       : qvr_pkg::MAG_W'(r_sum[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            m1_reg    <= m1_next;
            sq_reg    <= sq_next;
            q1_reg[0] <= quat_w;
            q1_reg[1] <= quat_x;
            q1_reg[2] <= quat_y;
            q1_reg[3] <= quat_z;
        end
        if (rdy[1])
        begin
            p_reg     <= p_next;
            q2_reg    <= q1_reg;
            den2_reg  <= den2_next;
            zero2_reg <= zero2_next;
        end
        if (rdy[2])
        begin
            m3_reg    <= m3_next;
            den3_reg  <= den2_reg;
            zero3_reg <= zero2_reg;
        end
        if (rdy[3])
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = v_reg[3];
    assign out_data  = res_reg;

endmodule

### hdl/qvr_divider.sv
// ----------------------------------------------------------------------------
// qvr_divider
// restoring divider, one quotient bit per stage, three lanes on a shared divisor
// computes round(mag / den) as (2*mag + den) / (2*den)
// ----------------------------------------------------------------------------
module qvr_divider
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  qvr_pkg::rot_res_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output qvr_pkg::div_res_t   out_data
);

    localparam int QW = qvr_pkg::QW;

    logic [QW-1:0]               v_reg;
    logic [QW:0]                 rdy;
    logic [qvr_pkg::D_W-1:0]     rem_reg [QW][3];
    logic [QW-1:0]               quo_reg [QW][3];
    logic [qvr_pkg::DIV_W-1:0]   s_reg [QW];
    logic [2:0]                  neg_reg [QW];
    logic                        zero_reg [QW];

    assign rdy[QW]  = out_ready;
    assign in_ready = rdy[0];

    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        localparam int B = QW - 1 - j;

        logic                        v_in;
        logic [qvr_pkg::D_W-1:0]     rem_in [3];
        logic [QW-1:0]               quo_in [3];
        logic [qvr_pkg::DIV_W-1:0]   s_in;
        logic [2:0]                  neg_in;
        logic                        zero_in;
        logic [qvr_pkg::D_W-1:0]     shifted;
        logic [qvr_pkg::D_W:0]       trial [3];
        logic [qvr_pkg::D_W-1:0]     rem_next [3];
        logic [QW-1:0]               quo_next [3];

        if (j == 0)
        begin : g_first
            always_comb
            begin
                v_in    = in_valid;
                s_in    = {in_data.den, 1'b0};
                neg_in  = in_data.neg;
                zero_in = in_data.zero;
                for (int i = 0; i < 3; i++)
                begin
                    rem_in[i] = {1'b0, in_data.mag[i], 1'b0}
                                + qvr_pkg::D_W'(in_data.den);
                    quo_in[i] = '0;
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                v_in    = v_reg[j-1];
                s_in    = s_reg[j-1];
                neg_in  = neg_reg[j-1];
                zero_in = zero_reg[j-1];
                for (int i = 0; i < 3; i++)
                begin
                    rem_in[i] = rem_reg[j-1][i];
                    quo_in[i] = quo_reg[j-1][i];
                end
            end
        end

        assign rdy[j] = !v_reg[j] || rdy[j+1];

        always_comb
        begin
            shifted = qvr_pkg::D_W'(s_in) << B;
            for (int i = 0; i < 3; i++)
            begin
                trial[i] = {1'b0, rem_in[i]} - {1'b0, shifted};
                if (!trial[i][qvr_pkg::D_W])
                begin
                    rem_next[i] = trial[i][qvr_pkg::D_W-1:0];
                    quo_next[i] = quo_in[i] | (QW'(1) << B);
                end
                else
                begin
                    rem_next[i] = rem_in[i];
                    quo_next[i] = quo_in[i];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (rdy[j])
            begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[j])
            begin
                rem_reg[j]  <= rem_next;
                quo_reg[j]  <= quo_next;
                s_reg[j]    <= s_in;
                neg_reg[j]  <= neg_in;
                zero_reg[j] <= zero_in;
            end
        end
    end

    always_comb
    begin
        out_data.neg  = neg_reg[QW-1];
        out_data.zero = zero_reg[QW-1];
        for (int i = 0; i < 3; i++)
        begin
            out_data.quo[i] = quo_reg[QW-1][i];
        end
    end

    assign out_valid = v_reg[QW-1];

endmodule

### verif/quaternion_vector_rotate_tb.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_tb
// rotates random and corner-case vectors by random, unit and degenerate
// quaternions and compares each world frame result against an exact
// integer prediction, under random idling on both sides and a long output hold
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_tb;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
    } sample_t;

    typedef struct packed {
        logic signed [16:0] rx;
        logic signed [16:0] ry;
        logic signed [16:0] rz;
        logic               err;
    } world_t;

    localparam int LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
    logic signed [15:0] accel_x, accel_y, accel_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [16:0] rot_x, rot_y, rot_z;
    logic               zero_quat_error;

    sample_t pending_samples[$];
    world_t  expected_world[$];
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_cycles;
    int      errors;
    int      results_seen;
    int      zero_seen;
    int      cycle_count;

    quaternion_vector_rotate u_top
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .quat_w          (quat_w),
        .quat_x          (quat_x),
        .quat_y          (quat_y),
        .quat_z          (quat_z),
        .accel_x         (accel_x),
        .accel_y         (accel_y),
        .accel_z         (accel_z),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .rot_x           (rot_x),
        .rot_y           (rot_y),
        .rot_z           (rot_z),
        .zero_quat_error (zero_quat_error)
    );

    function automatic logic signed [16:0] round_sat(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        if (num < 0)
        begin
            q = -q;
        end
        if (q > 65535)
        begin
            q = 65535;
        end
        if (q < -65536)
        begin
            q = -65536;
        end
        return q[16:0];
    endfunction

    function automatic world_t rotate_sample(sample_t s);
        world_t r;
        longint w, x, y, z, vx, vy, vz;
        longint n, one, pa, pb, pc, pd, rx, ry, rz, den;
        w = s.w;
        x = s.x;
        y = s.y;
        z = s.z;
        vx = s.ax;
        vy = s.ay;
        vz = s.az;
        n = w * w + x * x + y * y + z * z;
        one = longint'(1) << (2 * qvr_pkg::QUAT_FRAC_BITS);
        if (n == 0)
        begin
            r = '0;
            r.err = 1'b1;
            return r;
        end
        pa = -x * vx - y * vy - z * vz;
        pb = w * vx + y * vz - z * vy;
        pc = w * vy - x * vz + z * vx;
        pd = w * vz + x * vy - y * vx;
        rx = -pa * x + pb * w - pc * z + pd * y;
        ry = -pa * y + pb * z + pc * w - pd * x;
        rz = -pa * z - pb * y + pc * x + pd * w;
        den = (100 * n > 99 * one && 100 * n < 101 * one) ? one : n;
        r.rx = round_sat(rx, den);
        r.ry = round_sat(ry, den);
        r.rz = round_sat(rz, den);
        r.err = 1'b0;
        return r;
    endfunction

    function automatic logic [15:0] rand_field(int mode);
        case (mode)
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(16384 + $urandom_range(0, 400) - 200);
            3: return 16'($urandom_range(0, 8) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_sample(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                              logic [15:0] z, logic [15:0] ax, logic [15:0] ay,
                              logic [15:0] az);
        sample_t s;
        s = {w, x, y, z, ax, ay, az};
        pending_samples.push_back(s);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch on %s: got %0d expected %0d", what, got, want);
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            {quat_w, quat_x, quat_y, quat_z} <= '0;
            {accel_x, accel_y, accel_z} <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                expected_world.push_back(rotate_sample({quat_w, quat_x, quat_y, quat_z,
                                                        accel_x, accel_y, accel_z}));
            end
            if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                sample_t s;
                s = pending_samples.pop_front();
                in_valid <= 1'b1;
                {quat_w, quat_x, quat_y, quat_z} <= {s.w, s.x, s.y, s.z};
                {accel_x, accel_y, accel_z} <= {s.ax, s.ay, s.az};
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold right after reset
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cycles <= 200;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // receiver stall and monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_world.size() == 0)
                begin
                    report_mismatch("unexpected transaction", 1, 0);
                end
                else
                begin
                    world_t e;
                    e = expected_world.pop_front();
                    results_seen++;
                    if (e.err)
                    begin
                        zero_seen++;
                    end
                    if (rot_x !== e.rx) report_mismatch("rot_x", rot_x, e.rx);
                    if (rot_y !== e.ry) report_mismatch("rot_y", rot_y, e.ry);
                    if (rot_z !== e.rz) report_mismatch("rot_z", rot_z, e.rz);
                    if (zero_quat_error !== e.err)
                    begin
                        report_mismatch("zero_quat_error", zero_quat_error, e.err);
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] q[4];
        logic [15:0] v[3];
        errors = 0;
        results_seen = 0;
        zero_seen = 0;
        cycle_count = 0;
        send_idle_pct = 22;
        recv_idle_pct = 51;
        rst_n = 1'b0;

        // directed: identity, zero, extremes, boundaries of the unity band
        add_sample(16384, 0, 0, 0, 16'h7fff, 16'h8000, 1);
        add_sample(0, 0, 0, 0, 100, 200, 300);
        add_sample(0, 0, 0, 0, 16'h8000, 16'h7fff, 16'h8000);
        add_sample(0, 16384, 0, 0, 1000, -2000, 3000);
        add_sample(0, 0, 16384, 0, 1000, -2000, 3000);
        add_sample(0, 0, 0, 16384, 1000, -2000, 3000);
        add_sample(11585, 11585, 0, 0, 16'h7fff, 16'h7fff, 16'h7fff);
        add_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        add_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        add_sample(16'h8000, 0, 0, 0, 16'h7fff, 16'h8000, 16'h7fff);
        add_sample(16466, 0, 0, 0, 12345, -12345, 7);
        add_sample(16302, 0, 0, 0, 12345, -12345, 7);
        add_sample(16465, 0, 0, 0, 12345, -12345, 7);
        add_sample(16303, 0, 0, 0, 12345, -12345, 7);
        add_sample(1, 0, 0, 0, 3, -3, 1);
        add_sample(0, 1, 1, 0, 16'h7fff, 16'h8000, 5);
        add_sample(2, 0, 0, 0, 1, -1, 3);
        add_sample(16'hffff, 0, 0, 0, 16'h8000, 0, 16'h7fff);
        add_sample(8192, 8192, 8192, 8192, 16'h8000, 16'h8000, 16'h7fff);

        for (int i = 0; i < 1200; i++)
        begin
            int mode;
            mode = $urandom_range(0, 9);
            for (int k = 0; k < 4; k++)
            begin
                q[k] = (mode < 5) ? 16'($urandom_range(0, 32767) - 16384) :
                       rand_field($urandom_range(0, 5));
            end
            if (mode < 5)
            begin
                // rescale onto the unit sphere roughly, so most samples are near unity
                real nr;
                nr = $sqrt(real'($signed(q[0])) ** 2 + real'($signed(q[1])) ** 2 +
                           real'($signed(q[2])) ** 2 + real'($signed(q[3])) ** 2);
                if (nr > 0.0)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        q[k] = 16'($rtoi(real'($signed(q[k])) * 16384.0 / nr));
                    end
                end
            end
            else if (mode == 9)
            begin
                q = '{0, 0, 0, 0};
            end
            for (int k = 0; k < 3; k++)
            begin
                v[k] = rand_field($urandom_range(0, 7));
            end
            add_sample(q[0], q[1], q[2], q[3], v[0], v[1], v[2]);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_samples.size() < 800);
        @(posedge clk);
        send_idle_pct = 51;
        recv_idle_pct = 22;
        wait (pending_samples.size() < 400);
        @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait (pending_samples.size() == 0);
        @(posedge clk iff (!in_valid || !in_stall));
        @(posedge clk);
        wait (expected_world.size() == 0);
        repeat (40) @(posedge clk);

        $display("rotated %0d transactions, %0d with a zero quaternion, %0d mismatches",
                 results_seen, zero_seen, errors);
        if (errors == 0 && expected_world.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### quaternion_vector_rotate.f
hdl/qvr_pkg.sv
hdl/qvr_rotate.sv
hdl/qvr_divider.sv
hdl/quaternion_vector_rotate.sv
verif/quaternion_vector_rotate_tb.sv
